// File: rtl/cobs_frame_decoder_unit_defines.svh
// ----------------------------------------------------------------------------
// cobs_frame_decoder_unit_defines
// Assertion macros shared by the COBS frame decoder RTL.
// ----------------------------------------------------------------------------
`ifndef COBS_FRAME_DECODER_UNIT_DEFINES_SVH
`define COBS_FRAME_DECODER_UNIT_DEFINES_SVH

`ifndef SYNTH

// expression holds at every clock edge out of reset
`define CFD_ASSERT_ALWAYS(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("check failed: label");

// condition at one edge implies a consequence at the next edge
`define CFD_ASSERT_NEXT(label, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("check failed: label");

`else

`define CFD_ASSERT_ALWAYS(label, expr)
`define CFD_ASSERT_NEXT(label, cond, cons)

`endif

`endif

// File: rtl/cfd_pkg.sv
// ----------------------------------------------------------------------------
// cfd_pkg
// Types and constants of the COBS frame decoder.
// ----------------------------------------------------------------------------
package cfd_pkg;

    localparam int STORE_BYTES_DEF = 1024;
    localparam int MIN_LIMIT       = 255;
    localparam int LIMIT_RESET     = 1024;
    localparam int LIMIT_W         = 11;
    localparam int LEN_W           = 11;
    localparam int IDX_W           = 10;
    localparam int BYTE_W          = 8;
    localparam int ADDR_W          = 3;
    localparam int DATA_W          = 32;

    localparam logic [BYTE_W-1:0] CODE_NONE = 8'hFF;
    localparam logic [BYTE_W-1:0] CODE_END  = 8'h00;

    localparam logic KIND_STREAM   = 1'b0;
    localparam logic KIND_READ     = 1'b1;
    localparam logic RESULT_STATUS = 1'b0;
    localparam logic RESULT_READ   = 1'b1;

    typedef enum logic [0:0] {
        REG_FRAME_LIMIT = 1'b0,
        REG_UNUSED      = 1'b1
    } reg_index_t;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } store_ctl_t;

endpackage

// File: rtl/cfd_frame_store.sv
// ----------------------------------------------------------------------------
// cfd_frame_store
// Decoded frame byte store: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module cfd_frame_store
    import cfd_pkg::*;
#(
    parameter int DEPTH = STORE_BYTES_DEF,
    parameter int AW    = $clog2(DEPTH)
)
(
    input  logic              clk,
    input  store_ctl_t        ctl,
    input  logic [AW-1:0]     waddr,
    input  logic [BYTE_W-1:0] wdata,
    input  logic [AW-1:0]     raddr,
    output logic [BYTE_W-1:0] rdata
);

    logic [BYTE_W-1:0] mem_reg [DEPTH];
    logic [BYTE_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/cobs_frame_decoder_unit.sv
// ----------------------------------------------------------------------------
// cobs_frame_decoder_unit
// COBS frame decoder: decodes link bytes into a frame store, reports frame
// status at each delimiter and serves byte reads of the store.
// ----------------------------------------------------------------------------
//  channel   dir   handshake            payload
//  s_*       in    s_tvalid/s_tready    tuser kind, tdata in_byte/read_index
//  m_*       out   m_tvalid/m_tready    tuser result_kind, tdata status/read
//  p*        in    psel/penable/pready  frame_limit at address 0
//
//  One item per cycle while s_tready is high. Decode state sits in flops, updated in the accept cycle;
//  store writes happen at the accept edge, reads come back in the cycle after it.
//  A result passes a stage register then an output register.
//  Input stalls only when both stages hold results and m_tready is low.
//  Asynchronous active-low reset; the frame store is not cleared.
// ----------------------------------------------------------------------------
`include "cobs_frame_decoder_unit_defines.svh"

module cobs_frame_decoder_unit
    import cfd_pkg::*;
#(
    parameter int STORE_BYTES = STORE_BYTES_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [23:0]       s_tdata,   // [7:0] in_byte, [17:8] read_index
    input  logic              s_tuser,   // [0] kind
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [23:0]       m_tdata,   // [10:0] frame_length, [11] overflow,
                                         // [19:12] read_data
    output logic              m_tuser,   // [0] result_kind
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    localparam int AW = $clog2(STORE_BYTES);
    localparam int PW = $clog2(STORE_BYTES + 1);
    localparam int CW = (PW > LIMIT_W) ? PW : LIMIT_W;
    localparam int EFF_RESET = (LIMIT_RESET > STORE_BYTES) ? STORE_BYTES : LIMIT_RESET;

    // configuration
    logic [LIMIT_W-1:0] frame_limit_reg;
    logic [PW-1:0]      eff_limit_reg;
    logic [CW-1:0]      lim_wr;
    logic [PW-1:0]      eff_limit_next;
    logic               cfg_wr;
    reg_index_t         cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = reg_index_t'(paddr[2]);
    assign cfg_wr  = psel && penable && pwrite && pready && (cfg_idx == REG_FRAME_LIMIT);
    assign lim_wr  = CW'(pwdata[LIMIT_W-1:0]);

    always_comb
    begin
        if (lim_wr < CW'(MIN_LIMIT))
        begin
            eff_limit_next = PW'(MIN_LIMIT);
        end
        else if (lim_wr > CW'(STORE_BYTES))
        begin
            eff_limit_next = PW'(STORE_BYTES);
        end
        else
        begin
            eff_limit_next = PW'(lim_wr);
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_FRAME_LIMIT: prdata = DATA_W'(frame_limit_reg);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_limit_reg <= LIMIT_W'(LIMIT_RESET);
            eff_limit_reg   <= PW'(EFF_RESET);
        end
        else if (cfg_wr)
        begin
            frame_limit_reg <= pwdata[LIMIT_W-1:0];
            eff_limit_reg   <= eff_limit_next;
        end
    end

    // input decode
    logic              accept;
    logic              is_read;
    logic [BYTE_W-1:0] in_byte;
    logic [IDX_W-1:0]  read_index;
    logic [CW-1:0]     idx_ext;
    logic              idx_ok;

    assign accept     = s_tvalid && s_tready;
    assign is_read    = (s_tuser == KIND_READ);
    assign in_byte    = s_tdata[7:0];
    assign read_index = s_tdata[17:8];
    assign idx_ext    = CW'(read_index);
    assign idx_ok     = idx_ext < CW'(STORE_BYTES);

    // decoder state
    logic [BYTE_W-1:0] code_rem_reg, code_rem_next;
    logic [BYTE_W-1:0] last_code_reg, last_code_next;
    logic [PW-1:0]     wp_reg, wp_next;
    logic              ovf_reg, ovf_next;
    logic              store_req;
    logic [BYTE_W-1:0] store_val;
    logic              status_evt;
    store_ctl_t        st_ctl;
    logic [BYTE_W-1:0] st_rdata;

    always_comb
    begin
        code_rem_next  = code_rem_reg;
        last_code_next = last_code_reg;
        wp_next        = wp_reg;
        ovf_next       = ovf_reg;
        store_req      = 1'b0;
        store_val      = in_byte;
        status_evt     = 1'b0;
        st_ctl.wr_en   = 1'b0;
        st_ctl.rd_en   = accept && is_read && idx_ok;
        if (accept && !is_read)
        begin
            if (code_rem_reg != '0)
            begin
                store_req     = 1'b1;
                code_rem_next = code_rem_reg - 8'd1;
            end
            else if (in_byte == CODE_END)
            begin
                status_evt     = 1'b1;
                wp_next        = '0;
                ovf_next       = 1'b0;
                last_code_next = CODE_NONE;
            end
            else
            begin
                if (last_code_reg != CODE_NONE)
                begin
                    store_req = 1'b1;
                    store_val = '0;
                end
                last_code_next = in_byte;
                code_rem_next  = in_byte - 8'd1;
            end
        end
        if (store_req)
        begin
            if (wp_reg < eff_limit_reg)
            begin
                st_ctl.wr_en = 1'b1;
                wp_next      = wp_reg + PW'(1);
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_rem_reg  <= '0;
            last_code_reg <= CODE_NONE;
            wp_reg        <= '0;
            ovf_reg       <= 1'b0;
        end
        else
        begin
            code_rem_reg  <= code_rem_next;
            last_code_reg <= last_code_next;
            wp_reg        <= wp_next;
            ovf_reg       <= ovf_next;
        end
    end

    cfd_frame_store #(
        .DEPTH (STORE_BYTES),
        .AW    (AW)
    ) u_store (
        .clk   (clk),
        .ctl   (st_ctl),
        .waddr (wp_reg[AW-1:0]),
        .wdata (store_val),
        .raddr (idx_ext[AW-1:0]),
        .rdata (st_rdata)
    );

    // result stage and output register
    logic             s1_v_reg, s1_v_next;
    logic             s1_kind_reg;
    logic             s1_ok_reg;
    logic [LEN_W-1:0] s1_len_reg;
    logic             s1_ovf_reg;
    logic             s1_move;
    logic             out_v_reg, out_v_next;
    logic             out_kind_reg;
    logic [LEN_W-1:0] out_len_reg;
    logic             out_ovf_reg;
    logic [BYTE_W-1:0] out_data_reg;
    logic             has_result;

    assign has_result = accept && (is_read || status_evt);
    assign s1_move    = s1_v_reg && (!out_v_reg || m_tready);
    assign s_tready   = !s1_v_reg || !out_v_reg || m_tready;

    always_comb
    begin
        if (has_result)
        begin
            s1_v_next = 1'b1;
        end
        else if (s1_move)
        begin
            s1_v_next = 1'b0;
        end
        else
        begin
            s1_v_next = s1_v_reg;
        end
        if (s1_move)
        begin
            out_v_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_v_next = 1'b0;
        end
        else
        begin
            out_v_next = out_v_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            s1_v_reg  <= s1_v_next;
            out_v_reg <= out_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (has_result)
        begin
            s1_kind_reg <= is_read ? RESULT_READ : RESULT_STATUS;
            s1_ok_reg   <= idx_ok;
            s1_len_reg  <= is_read ? '0 : LEN_W'(wp_reg);
            s1_ovf_reg  <= is_read ? 1'b0 : ovf_reg;
        end
        if (s1_move)
        begin
            out_kind_reg <= s1_kind_reg;
            out_len_reg  <= s1_len_reg;
            out_ovf_reg  <= s1_ovf_reg;
            out_data_reg <= (s1_kind_reg == RESULT_READ && s1_ok_reg) ? st_rdata : '0;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {4'd0, out_data_reg, out_ovf_reg, out_len_reg};

    `CFD_ASSERT_ALWAYS(a_wp_in_store, wp_reg <= PW'(STORE_BYTES))
    `CFD_ASSERT_ALWAYS(a_code_below_last, code_rem_reg < last_code_reg)
    `CFD_ASSERT_ALWAYS(a_stall_only_full, s_tready || (s1_v_reg && out_v_reg && !m_tready))
    `CFD_ASSERT_NEXT(a_frame_end_clears, status_evt, (wp_reg == '0) && !ovf_reg && s1_v_reg)
    `CFD_ASSERT_NEXT(a_stage_moves, s1_move, out_v_reg)

endmodule
